>>> src/fra_pkg.sv
//------------------------------------------------------------------------------
// fra_pkg
// Shared types and constants for the frame release time adjuster.
//------------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

	localparam int unsigned NS_PER_US = 1000;

	typedef struct packed {
		logic        kind;
		logic [41:0] presentation_time_us;
		logic [61:0] unadjusted_release_ns;
		logic [61:0] vsync_reference_ns;
	} fra_in_t;

	typedef struct packed {
		logic signed [62:0] release_time_ns;
		logic               resynced;
	} fra_out_t;

	typedef enum logic [2:0] {
		CFG_USE_VSYNC  = 3'd0,
		CFG_PERIOD     = 3'd1,
		CFG_OFFSET     = 3'd2,
		CFG_MAX_DRIFT  = 3'd3,
		CFG_MIN_FRAMES = 3'd4
	} fra_cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_AVG,
		ST_CAND,
		ST_DRIFT,
		ST_COMMIT,
		ST_DIV_SNAP,
		ST_SNAP,
		ST_OUT
	} fra_state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic div_start;
		logic div_sel_snap;
		logic cand;
		logic drift;
		logic commit;
		logic snap;
		logic out_load;
	} fra_cmd_t;

	typedef struct packed {
		logic is_enable;
		logic need_avg;
		logic need_snap;
		logic div_done;
	} fra_sts_t;

endpackage

`default_nettype wire

>>> src/fra_div.sv
//------------------------------------------------------------------------------
// fra_div
// Radix-2 restoring unsigned divider, 64-bit, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module fra_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             done,
	output logic [63:0]      quotient,
	output logic [63:0]      remainder
);
	logic [63:0] rem_q, quo_q, dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	assign shifted = {rem_q, quo_q[63]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

`default_nettype wire

>>> src/fra_ctrl.sv
//------------------------------------------------------------------------------
// fra_ctrl
// Sequencer for the frame release time adjuster.
//------------------------------------------------------------------------------
`default_nettype none

module fra_ctrl import fra_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire fra_sts_t sts,
	output fra_cmd_t      cmd
);
	fra_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid && (!out_valid || out_ready)) state_d = ST_PREP;
			ST_PREP: begin
				if (sts.is_enable)     state_d = ST_IDLE;
				else if (sts.need_avg) state_d = ST_DIV_AVG;
				else                   state_d = ST_DRIFT;
			end
			ST_DIV_AVG:  if (sts.div_done) state_d = ST_CAND;
			ST_CAND:     state_d = ST_DRIFT;
			ST_DRIFT:    state_d = ST_COMMIT;
			ST_COMMIT:   state_d = sts.need_snap ? ST_DIV_SNAP : ST_OUT;
			ST_DIV_SNAP: if (sts.div_done) state_d = ST_SNAP;
			ST_SNAP:     state_d = ST_OUT;
			ST_OUT:      if (!out_valid || out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !out_valid || out_ready;
				cmd.load = in_valid && (!out_valid || out_ready);
			end
			ST_PREP: begin
				cmd.prep      = 1'b1;
				cmd.div_start = sts.need_avg && !sts.is_enable;
			end
			ST_CAND:   cmd.cand = 1'b1;
			ST_DRIFT:  cmd.drift = 1'b1;
			ST_COMMIT: begin
				cmd.commit       = 1'b1;
				cmd.div_start    = sts.need_snap;
				cmd.div_sel_snap = 1'b1;
			end
			ST_DIV_SNAP: cmd.div_sel_snap = 1'b1;
			ST_SNAP:     cmd.snap = 1'b1;
			ST_OUT:      cmd.out_load = !out_valid || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (out_ready)    out_valid <= 1'b0;
	end
endmodule

`default_nettype wire

>>> src/fra_dp.sv
//------------------------------------------------------------------------------
// fra_dp
// Datapath: sync state, averaging, drift check, vsync snapping.
//------------------------------------------------------------------------------
`default_nettype none

module fra_dp import fra_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire fra_cmd_t    cmd,
	input  wire fra_in_t     in_item,
	input  wire logic        cfg_valid,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output fra_sts_t         sts,
	output fra_out_t         out_item
);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic        use_vsync_q;
	logic [29:0] period_q, offset_q;
	logic [31:0] max_drift_q;
	logic [7:0]  min_frames_q;

	logic                  have_sync_q;
	logic [COUNT_BITS-1:0] frames_q;
	logic [41:0]           last_pus_q;
	logic [63:0]           pending_q, adj_last_q, sync_frame_q, sync_rel_q;

	fra_in_t     item_q;
	logic [63:0] fns_q, cand_q, adj_rel_q, res_q;
	logic        lost_q, resync_q;
	logic        avg_path_q;

	logic        div_done;
	logic [63:0] div_quo, div_rem, div_a, div_b, gap_avg, gap_snap;
	logic [63:0] d_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_vsync_q  <= 1'b0;
			period_q     <= 30'd16666666;
			offset_q     <= 30'd13333333;
			max_drift_q  <= 32'd20000000;
			min_frames_q <= 8'd6;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_USE_VSYNC:  use_vsync_q  <= cfg_data[0];
				CFG_PERIOD:     period_q     <= cfg_data[29:0];
				CFG_OFFSET:     offset_q     <= cfg_data[29:0];
				CFG_MAX_DRIFT:  max_drift_q  <= cfg_data;
				CFG_MIN_FRAMES: min_frames_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// counter after the presentation-change increment, combinational in PREP
	logic                  pus_new;
	logic [COUNT_BITS-1:0] frames_nx;
	logic                  avg_go;
	assign pus_new   = have_sync_q && (item_q.presentation_time_us != last_pus_q);
	assign frames_nx = (pus_new && frames_q != CNT_MAX) ? frames_q + 1'b1 : frames_q;
	assign avg_go    = have_sync_q &&
		({{(64-COUNT_BITS){1'b0}}, frames_nx} >= {56'd0, min_frames_q});
	assign d_frame   = fns_q - sync_frame_q;
	assign gap_avg   = d_frame[63] ? (64'd0 - d_frame) : d_frame;

	// drift check on candidate frame time
	logic [63:0]        chk_frame, chk_rel, ef, er, dgap;
	logic               drift_bad;
	assign chk_frame = avg_path_q ? cand_q : fns_q;
	assign chk_rel   = {2'b00, item_q.unadjusted_release_ns};
	assign ef        = chk_frame - sync_frame_q;
	assign er        = chk_rel - sync_rel_q;
	assign dgap      = ($signed(er) >= $signed(ef)) ? er - ef : ef - er;
	assign drift_bad = dgap > {32'd0, max_drift_q};

	// release time before snapping, taken at commit
	logic [63:0] adj_rel_nx;
	assign adj_rel_nx = (avg_path_q && !lost_q) ? sync_rel_q + cand_q - sync_frame_q : chk_rel;

	// snap inputs; the snap divide starts at commit from the time being committed
	logic signed [63:0] t_s, t_div, ref_s;
	logic [63:0]        per64;
	assign t_s      = adj_rel_q;
	assign t_div    = cmd.commit ? adj_rel_nx : adj_rel_q;
	assign ref_s    = {2'b00, item_q.vsync_reference_ns};
	assign per64    = (period_q == 30'd0) ? 64'd1 : {34'd0, period_q};
	assign gap_snap = (t_div >= ref_s) ? (t_div - ref_s) : (ref_s - t_div);

	assign div_a = cmd.div_sel_snap ? gap_snap : gap_avg;
	assign div_b = cmd.div_sel_snap ? per64 : {{(64-COUNT_BITS){1'b0}}, frames_nx};

	fra_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_quo),
		.remainder(div_rem)
	);

	// snapping; whole periods spanned = gap less remainder
	logic [63:0] span, snapped, s_before, s_after, snap_res;
	assign span    = gap_snap - div_rem;
	assign snapped = (t_s >= ref_s) ? ref_s + span : ref_s - span;
	always_comb begin
		if (t_s <= $signed(snapped)) begin
			s_before = snapped - per64;
			s_after  = snapped;
		end else begin
			s_before = snapped;
			s_after  = snapped + per64;
		end
		snap_res = ((s_after - t_s) < (t_s - s_before)) ? s_after : s_before;
		snap_res = snap_res - {34'd0, offset_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
			fns_q  <= in_item.presentation_time_us * 64'(NS_PER_US);
		end
		if (cmd.prep) begin
			avg_path_q <= avg_go;
			lost_q     <= 1'b0;
			if (avg_go && frames_nx == '0) cand_q <= adj_last_q;
		end
		if (cmd.cand) begin
			if (frames_q == '0) cand_q <= adj_last_q;
			else cand_q <= adj_last_q + (d_frame[63] ? 64'd0 - div_quo : div_quo);
		end
		if (cmd.drift) lost_q <= have_sync_q && drift_bad;
		if (cmd.commit) adj_rel_q <= adj_rel_nx;
		if (cmd.snap) res_q <= snap_res;
	end

	// state update at prep and commit
	logic resync;
	assign resync = !have_sync_q || lost_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_sync_q  <= 1'b0;
			frames_q     <= '0;
			last_pus_q   <= '0;
			pending_q    <= '0;
			adj_last_q   <= '0;
			sync_frame_q <= '0;
			sync_rel_q   <= '0;
			resync_q     <= 1'b0;
		end else begin
			if (cmd.prep && item_q.kind) have_sync_q <= 1'b0;
			else if (cmd.prep) begin
				frames_q <= frames_nx;
				if (pus_new) adj_last_q <= pending_q;
			end
			if (cmd.commit) begin
				resync_q   <= resync;
				last_pus_q <= item_q.presentation_time_us;
				pending_q  <= (avg_path_q && !lost_q) ? cand_q : fns_q;
				if (resync) begin
					sync_frame_q <= fns_q;
					sync_rel_q   <= chk_rel;
					frames_q     <= '0;
					have_sync_q  <= 1'b1;
				end
			end
		end
	end

	// final saturate into the signed 63-bit range
	logic [63:0] final_v;
	logic        snapping_q;
	always_ff @(posedge clk) if (cmd.commit) snapping_q <= sts.need_snap;
	assign final_v = snapping_q ? res_q : adj_rel_q;

	logic signed [62:0] sat;
	always_comb begin
		if ($signed(final_v) > $signed({2'b00, {62{1'b1}}}))
			sat = {1'b0, {62{1'b1}}};
		else if ($signed(final_v) < $signed({2'b11, 62'd0}))
			sat = {1'b1, 62'd0};
		else
			sat = final_v[62:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_item.release_time_ns <= sat;
			out_item.resynced        <= resync_q;
		end
	end

	assign sts.is_enable = item_q.kind;
	assign sts.need_avg  = avg_go && frames_nx != '0;
	assign sts.need_snap = use_vsync_q && (item_q.vsync_reference_ns != '0);
	assign sts.div_done  = div_done;
endmodule

`default_nettype wire

>>> src/frame_release_time_adjuster.sv
//------------------------------------------------------------------------------
// frame_release_time_adjuster
// Smooths video frame release times with optional vsync snapping.
//
// Input channel (in_valid/in_ready/in_data) takes one item at a time; a frame
// item yields one result on out_valid/out_ready/out_data, an enable item none.
// Config writes (cfg_valid/cfg_ready/cfg_index/cfg_data) are taken every cycle
// and must only be issued while the block is idle.
// From acceptance a frame item passes prepare, the averaging divide and
// candidate step when averaging applies, drift check, commit, the vsync divide
// and snap step when snapping, and output; an enable item ends at prepare.
// Both divides use the shared 64-bit bit-serial divider. Reset clears sync
// state and loads register defaults. If the receiver stalls the result is
// held in the output register and no new item is taken until it leaves.
//------------------------------------------------------------------------------
`default_nettype none

module frame_release_time_adjuster import fra_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire fra_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output fra_out_t         out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	fra_cmd_t cmd;
	fra_sts_t sts;

	assign cfg_ready = 1'b1;

	fra_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	fra_dp #(.COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_item(in_data),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.sts(sts), .out_item(out_data)
	);
endmodule

`default_nettype wire

>>> src/fra_checker.sv
//------------------------------------------------------------------------------
// fra_checker
// Port-level checks for the frame release time adjuster.
//------------------------------------------------------------------------------
`default_nettype none

module fra_checker import fra_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_ready,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire fra_out_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped under stall");

	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while busy");

	a_no_take_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");
endmodule

bind frame_release_time_adjuster fra_checker u_fra_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

`default_nettype wire

>>> test/frame_release_time_adjuster_checker.sv
//------------------------------------------------------------------------------
// frame_release_time_adjuster_checker
// Watches the input, output and config channels of the frame release time
// adjuster, predicts each frame's release time and compares every result
// transaction against the oldest prediction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_release_time_adjuster_checker import fra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  fra_in_t     in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  fra_out_t    out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending_count,
	output int          release_count,
	output int          resync_count
);

	localparam logic [63:0] COUNT_MAX = 64'hFFFF_FFFF;
	localparam logic signed [63:0] RES_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] RES_MIN = -64'sh4000_0000_0000_0000;

	logic        use_vsync;
	logic [29:0] period_ns;
	logic [29:0] offset_ns;
	logic [31:0] max_drift;
	logic [7:0]  min_frames;

	logic        synced;
	logic [63:0] frame_count;
	logic [41:0] last_pts_us;
	logic [63:0] next_adj_frame;
	logic [63:0] last_adj_frame;
	logic [63:0] sync_frame;
	logic [63:0] sync_release;

	fra_out_t release_queue[$];

	function automatic logic [63:0] gap_of(logic signed [63:0] a, logic signed [63:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic drift_over(logic [63:0] frame_ns, logic [63:0] rel_ns);
		logic signed [63:0] ef;
		logic signed [63:0] er;
		ef = frame_ns - sync_frame;
		er = rel_ns - sync_release;
		return gap_of(er, ef) > {32'd0, max_drift};
	endfunction

	function automatic logic [63:0] snap_to_grid(logic signed [63:0] t,
			logic signed [63:0] r, logic [63:0] p);
		logic [63:0] span;
		logic [63:0] snapped;
		logic [63:0] lo;
		logic [63:0] hi;
		span = (gap_of(t, r) / p) * p;
		snapped = (t >= r) ? r + span : r - span;
		if (t <= $signed(snapped)) begin
			lo = snapped - p;
			hi = snapped;
		end else begin
			lo = snapped;
			hi = snapped + p;
		end
		return ((hi - t) < (t - lo)) ? hi : lo;
	endfunction

	task automatic predict_release(fra_in_t it);
		logic [63:0] fns;
		logic [63:0] adj_frame;
		logic [63:0] adj_rel;
		logic [63:0] avg;
		logic [63:0] cand;
		logic [63:0] q;
		logic [63:0] p;
		logic signed [63:0] d;
		logic signed [63:0] res;
		logic resync;
		fra_out_t exp_item;
		resync = 1'b0;
		fns = {22'd0, it.presentation_time_us} * 64'd1000;
		adj_frame = fns;
		adj_rel = {2'd0, it.unadjusted_release_ns};
		if (synced) begin
			if (it.presentation_time_us != last_pts_us) begin
				if (frame_count < COUNT_MAX)
					frame_count = frame_count + 1;
				last_adj_frame = next_adj_frame;
			end
			if (frame_count >= {56'd0, min_frames}) begin
				avg = 0;
				if (frame_count != 0) begin
					d = fns - sync_frame;
					q = gap_of(d, 0) / frame_count;
					avg = (d >= 0) ? q : -q;
				end
				cand = last_adj_frame + avg;
				if (drift_over(cand, adj_rel)) begin
					synced = 1'b0;
				end else begin
					adj_frame = cand;
					adj_rel = sync_release + cand - sync_frame;
				end
			end else if (drift_over(fns, adj_rel)) begin
				synced = 1'b0;
			end
		end
		if (!synced) begin
			sync_frame = fns;
			sync_release = {2'd0, it.unadjusted_release_ns};
			frame_count = 0;
			synced = 1'b1;
			resync = 1'b1;
		end
		last_pts_us = it.presentation_time_us;
		next_adj_frame = adj_frame;
		res = adj_rel;
		if (use_vsync && it.vsync_reference_ns != 0) begin
			p = (period_ns != 0) ? {34'd0, period_ns} : 64'd1;
			res = snap_to_grid(res, {2'd0, it.vsync_reference_ns}, p) - {34'd0, offset_ns};
		end
		if (res > RES_MAX)
			res = RES_MAX;
		if (res < RES_MIN)
			res = RES_MIN;
		exp_item.release_time_ns = res[62:0];
		exp_item.resynced = resync;
		release_queue.push_back(exp_item);
	endtask

	assign pending_count = release_queue.size();

	always @(posedge clk or negedge arst_n) begin
		fra_out_t want;
		if (!arst_n) begin
			use_vsync <= 1'b0;
			period_ns <= 30'd16666666;
			offset_ns <= 30'd13333333;
			max_drift <= 32'd20000000;
			min_frames <= 8'd6;
			synced = 1'b0;
			frame_count = 0;
			last_pts_us = 0;
			next_adj_frame = 0;
			last_adj_frame = 0;
			sync_frame = 0;
			sync_release = 0;
			release_queue.delete();
			fail_count <= 0;
			release_count <= 0;
			resync_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (fra_cfg_idx_t'(cfg_index))
					CFG_USE_VSYNC:  use_vsync <= cfg_data[0];
					CFG_PERIOD:     period_ns <= cfg_data[29:0];
					CFG_OFFSET:     offset_ns <= cfg_data[29:0];
					CFG_MAX_DRIFT:  max_drift <= cfg_data;
					CFG_MIN_FRAMES: min_frames <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				release_count <= release_count + 1;
				if (out_data.resynced)
					resync_count <= resync_count + 1;
				if (release_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transaction: %h", out_data);
					fail_count <= fail_count + 1;
				end else begin
					want = release_queue.pop_front();
					if (want !== out_data) begin
						if (fail_count < 10)
							$display("result differs: exp time %0d resync %0b, got time %0d resync %0b",
								want.release_time_ns, want.resynced,
								out_data.release_time_ns, out_data.resynced);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.kind)
					synced = 1'b0;
				else
					predict_release(in_data);
			end
		end
	end

endmodule

>>> test/frame_release_time_adjuster_test.sv
//------------------------------------------------------------------------------
// frame_release_time_adjuster_test
// Drives directed and random frame and enable transactions through the frame
// release time adjuster under several register settings, with random gaps on
// both channels, and reports the checker's verdict.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_release_time_adjuster_test;
	import fra_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	fra_in_t     in_data;
	logic        out_valid;
	logic        out_ready;
	fra_out_t    out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          fail_count;
	int          pending_count;
	int          release_count;
	int          resync_count;
	int          idle_cycles;
	int          frames_sent;
	int          enables_sent;
	logic        sink_random;

	logic [41:0] pts_us;
	logic [61:0] rel_ns;
	logic [61:0] vref_ns;

	frame_release_time_adjuster u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	frame_release_time_adjuster_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count),
		.release_count(release_count), .resync_count(resync_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 200);
		if ($urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 4);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	always @(posedge clk) begin
		if (!sink_random)
			out_ready <= 1'b1;
		else if ($urandom_range(0, 29) == 0)
			out_ready <= 1'b0;
		else if (!out_ready && $urandom_range(0, 3) != 0)
			out_ready <= 1'b0;
		else
			out_ready <= 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("frame_release_time_adjuster: mismatch");
			$finish;
		end
	end

	// valid stays up between back-to-back transactions; drain() drops it
	task automatic send_item(fra_in_t it);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		if (it.kind)
			enables_sent++;
		else
			frames_sent++;
	endtask

	task automatic send_frame(logic [41:0] p, logic [61:0] r, logic [61:0] v);
		fra_in_t it;
		it.kind = 1'b0;
		it.presentation_time_us = p;
		it.unadjusted_release_ns = r;
		it.vsync_reference_ns = v;
		send_item(it);
	endtask

	task automatic send_enable();
		fra_in_t it;
		it.kind = 1'b1;
		it.presentation_time_us = 42'(rand64());
		it.unadjusted_release_ns = 62'(rand64());
		it.vsync_reference_ns = 62'(rand64());
		send_item(it);
	endtask

	task automatic write_reg(fra_cfg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (160) @(posedge clk);
	endtask

	task automatic set_regs(logic uv, logic [29:0] per, logic [29:0] off,
			logic [31:0] drift, logic [7:0] minf);
		drain();
		write_reg(CFG_USE_VSYNC, {31'd0, uv});
		write_reg(CFG_PERIOD, {2'd0, per});
		write_reg(CFG_OFFSET, {2'd0, off});
		write_reg(CFG_MAX_DRIFT, drift);
		write_reg(CFG_MIN_FRAMES, {24'd0, minf});
		cfg_valid <= 1'b0;
	endtask

	// steady cadence with jitter, repeats, jumps, random frames, enables
	task automatic run_stream(int n, logic [61:0] vper);
		int k;
		int sel;
		for (k = 0; k < n; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 3) begin
				send_enable();
			end else if (sel < 8) begin
				send_frame(42'(rand64()), 62'(rand64()), 62'(rand64()));
			end else begin
				if (sel >= 12)
					pts_us = pts_us + 42'd16667 + $urandom_range(0, 40) - 20;
				rel_ns = rel_ns + 62'd16667000 + $urandom_range(0, 8000000) - 4000000;
				if (sel < 20)
					rel_ns = rel_ns + $urandom_range(0, 60000000);
				if ($urandom_range(0, 9) == 0)
					vref_ns = 0;
				else
					vref_ns = rel_ns - $urandom_range(0, 30000000) + vper;
				send_frame(pts_us, rel_ns, vref_ns);
			end
		end
	endtask

	initial begin
		int ph;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_USE_VSYNC;
		cfg_data = '0;
		out_ready = 1'b1;
		sink_random = 1'b0;
		frames_sent = 0;
		enables_sent = 0;
		pts_us = 42'd1000;
		rel_ns = 62'd5000000000;
		vref_ns = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, repeats, enables, drift, vsync ties
		send_frame(42'd0, 62'd0, 62'd0);
		send_frame(42'd0, 62'd0, 62'd0);
		send_frame('1, '1, '1);
		send_enable();
		send_frame('1, '1, 62'd0);
		send_frame(42'd100, 62'd100000, 62'd0);
		send_frame(42'd50, 62'd50000, 62'd0);
		set_regs(1'b1, 30'd10, 30'd0, 32'd0, 8'd0);
		send_frame(42'd1, 62'd15, 62'd10);
		send_frame(42'd2, 62'd2000, 62'd5);
		send_frame(42'd2, 62'd25, '1);
		send_frame('1, 62'd1, 62'd1);
		set_regs(1'b1, 30'd0, 30'd1000000000, 32'hFFFF_FFFF, 8'd255);
		send_frame(42'd10, 62'd10000, 62'd3);
		send_frame(42'd20, 62'd20000, 62'd3);
		send_frame('1, 62'd0, '1);
		set_regs(1'b1, 30'd1000000000, 30'd0, 32'hFFFF_FFFF, 8'd0);
		send_frame(42'd0, '1, 62'd1);
		send_frame('1, 62'd0, '1);
		send_frame(42'd5, 62'd1000000000, 62'd500000000);
		send_enable();
		send_frame(42'd7, 62'd7000, 62'd0);

		sink_random = 1'b1;
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_regs(1'b0, 30'd16666666, 30'd13333333, 32'd20000000, 8'd6);
				1: set_regs(1'b1, 30'd16666666, 30'd13333333, 32'd20000000, 8'd6);
				2: set_regs(1'b1, 30'd1, 30'd0, 32'd0, 8'd0);
				3: set_regs(1'b1, 30'd1000000000, 30'd1000000000, 32'hFFFF_FFFF, 8'd255);
				4: set_regs(1'b1, 30'd8333333, 30'd2000000, 32'd50000000, 8'd1);
				5: set_regs(1'b0, 30'd0, 30'd0, 32'd5000000, 8'd3);
				6: set_regs(1'b1, 30'($urandom), 30'($urandom), $urandom, 8'($urandom));
				default: set_regs(1'b1, 30'd16666666, 30'd500000, 32'd30000000, 8'd2);
			endcase
			run_stream(200, 62'd16666666);
		end

		drain();
		$display("covered %0d frame and %0d enable transactions, %0d results, %0d resyncs",
			frames_sent, enables_sent, release_count, resync_count);
		if (fail_count == 0)
			$display("frame_release_time_adjuster: match");
		else
			$display("frame_release_time_adjuster: mismatch");
		$finish;
	end

endmodule
